/* hdl/bsab_pkg.sv */
// ----------------------------------------------------------------------------
// bsab_pkg
// Shared types, constants and the channel mix function of the bilinear
// sample and alpha blend unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bsab_pkg;

    localparam int BLUR_TEXELS = 4096;
    localparam int ADDR_W      = $clog2(BLUR_TEXELS);
    localparam int CHANNELS    = 4;
    localparam int CHAN_W      = 16;
    localparam int PIX_W       = CHANNELS * CHAN_W;
    localparam int FRAC_W      = 16;
    localparam int COORD_W     = 32;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_IDX_W-1:0] REG_PITCH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_U = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_V = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_U  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_V  = 3'd4;

    localparam logic CMD_TEXEL = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 16'hFFFF;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [PIX_W-1:0]  pixel_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_TOP,
        OP_BOT,
        OP_VMIX,
        OP_BLEND
    } lane_op_t;

    typedef struct packed {
        lane_op_t op;
        chan_t    weight;
    } lane_ctl_t;

    // (a*(65535-f) + b*f + 65535) >> 16, rewritten with one product
    function automatic chan_t mix16(input chan_t a, input chan_t b, input chan_t f);
        logic signed [CHAN_W:0]       diff;
        logic signed [2*CHAN_W+1:0]   prod;
        logic signed [2*CHAN_W+1:0]   sum;
        diff = $signed({1'b0, b}) - $signed({1'b0, a});
        prod = diff * $signed({1'b0, f});
        sum  = $signed({2'b00, a, 16'h0000}) + prod
             + $signed({18'h00000, CHAN_MAX - a});
        return sum[2*CHAN_W-1:CHAN_W];
    endfunction

endpackage

`default_nettype wire

/* hdl/bsab_store.sv */
// ----------------------------------------------------------------------------
// bsab_store
// Single-port blur texel memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bsab_store (
    input  wire logic                       aclk,
    input  wire logic                       we,
    input  wire logic [bsab_pkg::ADDR_W-1:0] addr,
    input  wire bsab_pkg::pixel_t            wdata,
    output bsab_pkg::pixel_t                 rdata
);

    bsab_pkg::pixel_t mem [bsab_pkg::BLUR_TEXELS];
    bsab_pkg::pixel_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hdl/bsab_lane.sv */
// ----------------------------------------------------------------------------
// bsab_lane
// One channel lane: a shared mix unit stepping through horizontal, vertical
// and blend passes for its channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bsab_lane (
    input  wire logic                aclk,
    input  wire bsab_pkg::lane_ctl_t ctl,
    input  wire bsab_pkg::chan_t     rd_chan,
    input  wire bsab_pkg::chan_t     dest_chan,
    output bsab_pkg::chan_t          result
);

    bsab_pkg::chan_t hold_reg;
    bsab_pkg::chan_t top_reg;
    bsab_pkg::chan_t bot_reg;
    bsab_pkg::chan_t res_reg;
    bsab_pkg::chan_t mix_a;
    bsab_pkg::chan_t mix_b;
    bsab_pkg::chan_t mix_out;

    always_comb begin
        unique case (ctl.op)
            bsab_pkg::OP_VMIX: begin
                mix_a = top_reg;
                mix_b = bot_reg;
            end
            bsab_pkg::OP_BLEND: begin
                mix_a = dest_chan;
                mix_b = top_reg;
            end
            default: begin
                mix_a = hold_reg;
                mix_b = rd_chan;
            end
        endcase
        mix_out = bsab_pkg::mix16(mix_a, mix_b, ctl.weight);
    end

    always_ff @(posedge aclk) begin
        unique case (ctl.op)
            bsab_pkg::OP_LOAD:  hold_reg <= rd_chan;
            bsab_pkg::OP_TOP:   top_reg  <= mix_out;
            bsab_pkg::OP_BOT:   bot_reg  <= mix_out;
            bsab_pkg::OP_VMIX:  top_reg  <= mix_out;
            bsab_pkg::OP_BLEND: res_reg  <= mix_out;
            default: begin
            end
        endcase
    end

    assign result = res_reg;

endmodule

`default_nettype wire

/* hdl/bsab_ctrl.sv */
// ----------------------------------------------------------------------------
// bsab_ctrl
// Request sequencer: configuration registers, sample coordinates, texel
// address generation and the lane step schedule.
// ----------------------------------------------------------------------------
`default_nettype none

module bsab_ctrl (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    input  wire logic [bsab_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bsab_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           req_valid,
    output logic                                req_ready,
    input  wire logic                           req_cmd,
    input  wire logic                           req_region_first,
    input  wire logic                           req_row_last,
    input  wire logic [bsab_pkg::ADDR_W-1:0]     req_texel_index,
    input  wire bsab_pkg::chan_t                 req_mask,
    input  wire bsab_pkg::pixel_t                req_dest,
    input  wire logic                           out_free,
    output logic                                mem_we,
    output logic [bsab_pkg::ADDR_W-1:0]          mem_addr,
    output bsab_pkg::lane_ctl_t                  lane_ctl,
    output bsab_pkg::pixel_t                     dest,
    output logic                                bypass,
    output logic                                out_load
);

    typedef enum logic [3:0] {
        S_IDLE, S_ADDR, S_RD0, S_RD1, S_RD2, S_RD3, S_BOT, S_VMIX, S_BLEND, S_DONE
    } state_t;

    localparam int AW = bsab_pkg::ADDR_W;
    localparam int CW = bsab_pkg::COORD_W;
    localparam int FW = bsab_pkg::FRAC_W;

    state_t               state_reg;
    logic [6:0]           pitch_reg;
    logic [21:0]          start_u_reg;
    logic [21:0]          start_v_reg;
    logic [23:0]          step_u_reg;
    logic [23:0]          step_v_reg;
    logic [CW-1:0]        cur_u_reg;
    logic [CW-1:0]        cur_v_reg;
    logic [CW-1:0]        u_reg;
    logic [CW-1:0]        v_reg;
    logic [AW-1:0]        base_reg;
    bsab_pkg::chan_t      mask_reg;
    bsab_pkg::pixel_t     dest_reg;
    logic                 bypass_reg;

    logic                 accept;
    logic [CW-1:0]        eff_u;
    logic [CW-1:0]        eff_v;
    logic [CW-1:0]        cur_u_next;
    logic [CW-1:0]        cur_v_next;
    logic [AW+6:0]        row_prod;
    logic [AW-1:0]        base_next;
    logic [AW-1:0]        pitch_ext;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign mem_we    = accept && (req_cmd == bsab_pkg::CMD_TEXEL);
    assign out_load  = (state_reg == S_DONE) && out_free;
    assign dest      = dest_reg;
    assign bypass    = bypass_reg;
    assign pitch_ext = AW'(pitch_reg);

    always_comb begin
        eff_u = req_region_first ? CW'(start_u_reg) : cur_u_reg;
        eff_v = req_region_first ? CW'(start_v_reg) : cur_v_reg;
        if (req_row_last) begin
            cur_u_next = CW'(start_u_reg);
            cur_v_next = eff_v + {{(CW-24){step_v_reg[23]}}, step_v_reg};
        end else begin
            cur_u_next = eff_u + {{(CW-24){step_u_reg[23]}}, step_u_reg};
            cur_v_next = eff_v;
        end
        row_prod  = v_reg[FW +: AW] * pitch_reg;
        base_next = row_prod[AW-1:0] + u_reg[FW +: AW];
    end

    always_comb begin
        lane_ctl.op     = bsab_pkg::OP_NONE;
        lane_ctl.weight = u_reg[FW-1:0];
        mem_addr        = base_reg;
        unique case (state_reg)
            S_IDLE: mem_addr = req_texel_index;
            S_RD0:  mem_addr = base_reg;
            S_RD1: begin
                mem_addr    = base_reg + AW'(1);
                lane_ctl.op = bsab_pkg::OP_LOAD;
            end
            S_RD2: begin
                mem_addr    = base_reg + pitch_ext;
                lane_ctl.op = bsab_pkg::OP_TOP;
            end
            S_RD3: begin
                mem_addr    = base_reg + pitch_ext + AW'(1);
                lane_ctl.op = bsab_pkg::OP_LOAD;
            end
            S_BOT:  lane_ctl.op = bsab_pkg::OP_BOT;
            S_VMIX: begin
                lane_ctl.op     = bsab_pkg::OP_VMIX;
                lane_ctl.weight = v_reg[FW-1:0];
            end
            S_BLEND: begin
                lane_ctl.op     = bsab_pkg::OP_BLEND;
                lane_ctl.weight = mask_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pitch_reg   <= 7'd64;
            start_u_reg <= '0;
            start_v_reg <= '0;
            step_u_reg  <= 24'h010000;
            step_v_reg  <= 24'h010000;
            cur_u_reg   <= '0;
            cur_v_reg   <= '0;
            bypass_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    bsab_pkg::REG_PITCH:   pitch_reg   <= cfg_data[6:0];
                    bsab_pkg::REG_START_U: start_u_reg <= cfg_data[21:0];
                    bsab_pkg::REG_START_V: start_v_reg <= cfg_data[21:0];
                    bsab_pkg::REG_STEP_U:  step_u_reg  <= cfg_data;
                    bsab_pkg::REG_STEP_V:  step_v_reg  <= cfg_data;
                    default: begin
                    end
                endcase
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept && req_cmd == bsab_pkg::CMD_PIXEL) begin
                        u_reg      <= eff_u;
                        v_reg      <= eff_v;
                        cur_u_reg  <= cur_u_next;
                        cur_v_reg  <= cur_v_next;
                        mask_reg   <= req_mask;
                        dest_reg   <= req_dest;
                        bypass_reg <= (req_mask == '0);
                        state_reg  <= (req_mask == '0) ? S_DONE : S_ADDR;
                    end
                end
                S_ADDR: begin
                    base_reg  <= base_next;
                    state_reg <= S_RD0;
                end
                S_RD0:   state_reg <= S_RD1;
                S_RD1:   state_reg <= S_RD2;
                S_RD2:   state_reg <= S_RD3;
                S_RD3:   state_reg <= S_BOT;
                S_BOT:   state_reg <= S_VMIX;
                S_VMIX:  state_reg <= S_BLEND;
                S_BLEND: state_reg <= S_DONE;
                S_DONE: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

/* hdl/bilinear_sample_alpha_blend_unit.sv */
// ----------------------------------------------------------------------------
// bilinear_sample_alpha_blend_unit
// Bilinear blur sampler with mask-weighted blend over four 16-bit channels.
// ----------------------------------------------------------------------------
// A texel-write request is written to the blur store as it is accepted. A
// pixel request with a zero mask skips the sampler and hands its destination
// pixel to the output register. Any other pixel request goes through the
// texel address, the four neighbor reads through the single-port blur
// store, then the bottom horizontal mix, the vertical mix and the blend,
// each a step of the per-channel mix unit, and then the hand-off to the
// output register. One request is in work at a time; a finished result
// waits in the output register while the next request is taken. Texel
// addresses wrap modulo the store size.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_sample_alpha_blend_unit (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [23:0]   cfg_data,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // texel_index[11:0], texel_value[75:12], mask_weight[91:76],
    // dest_pixel[155:92], zero pad[159:156]
    input  wire logic [159:0]  s_tdata,
    // cmd[0], region_first[1]
    input  wire logic [1:0]    s_tuser,
    input  wire logic          s_tlast,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // blended_pixel[63:0]
    output logic [63:0]        m_tdata
);

    localparam int CH = bsab_pkg::CHANNELS;
    localparam int CW = bsab_pkg::CHAN_W;

    logic                          out_free;
    logic                          mem_we;
    logic [bsab_pkg::ADDR_W-1:0]   mem_addr;
    bsab_pkg::pixel_t              mem_rdata;
    bsab_pkg::lane_ctl_t           lane_ctl;
    bsab_pkg::pixel_t              dest;
    bsab_pkg::pixel_t              lane_res;
    logic                          bypass;
    logic                          out_load;
    logic                          m_tvalid_reg;
    logic                          m_tvalid_next;
    bsab_pkg::pixel_t              m_tdata_reg;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    bsab_ctrl u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .req_valid        (s_tvalid),
        .req_ready        (s_tready),
        .req_cmd          (s_tuser[0]),
        .req_region_first (s_tuser[1]),
        .req_row_last     (s_tlast),
        .req_texel_index  (s_tdata[11:0]),
        .req_mask         (s_tdata[91:76]),
        .req_dest         (s_tdata[155:92]),
        .out_free         (out_free),
        .mem_we           (mem_we),
        .mem_addr         (mem_addr),
        .lane_ctl         (lane_ctl),
        .dest             (dest),
        .bypass           (bypass),
        .out_load         (out_load)
    );

    bsab_store u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (s_tdata[75:12]),
        .rdata (mem_rdata)
    );

    for (genvar c = 0; c < CH; c++) begin : g_lane
        bsab_lane u_lane (
            .aclk      (aclk),
            .ctl       (lane_ctl),
            .rd_chan   (mem_rdata[c*CW +: CW]),
            .dest_chan (dest[c*CW +: CW]),
            .result    (lane_res[c*CW +: CW])
        );
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        if (out_load) begin
            m_tdata_reg <= bypass ? dest : lane_res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bilinear sample and alpha blend unit. Requests
// are queued ahead and fed through the input stream with random gaps. The
// register file is rewritten between phases, while the unit is idle. A
// scoreboard tracks the blur store, the sample position and the registers.
// It predicts every blended pixel and compares it with what leaves the
// output stream. Taps are always written before any pixel reads them.
// ----------------------------------------------------------------------------

module tb_top;

    localparam int ADDR_W      = bsab_pkg::ADDR_W;
    localparam int CHAN_W      = bsab_pkg::CHAN_W;
    localparam int FRAC_W      = bsab_pkg::FRAC_W;
    localparam int CHANNELS    = bsab_pkg::CHANNELS;
    localparam int BLUR_TEXELS = bsab_pkg::BLUR_TEXELS;
    localparam int CFG_IDX_W   = bsab_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = bsab_pkg::CFG_DATA_W;

    typedef struct packed {
        logic               cmd;
        logic [ADDR_W-1:0]  tex_idx;
        bsab_pkg::pixel_t   tex_val;
        bsab_pkg::chan_t    mask;
        bsab_pkg::pixel_t   dest;
        logic               row_last;
        logic               region_first;
    } blend_req_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [159:0]          s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [63:0]           m_tdata;

    // scoreboard copy of the unit's registers and state
    logic [6:0]        pitch_r   = 7'd64;
    logic [21:0]       start_u_r = '0;
    logic [21:0]       start_v_r = '0;
    logic [23:0]       step_u_r  = 24'h010000;
    logic [23:0]       step_v_r  = 24'h010000;
    logic [31:0]       pos_u = '0;
    logic [31:0]       pos_v = '0;
    bsab_pkg::pixel_t  blur_img [BLUR_TEXELS];

    // request planning: sample position and the set of texels written so far
    logic [31:0]  plan_u = '0;
    logic [31:0]  plan_v = '0;
    bit           filled [BLUR_TEXELS];

    blend_req_t        pending_requests [$];
    bsab_pkg::pixel_t  blend_due [$];
    blend_req_t        offer = '0;
    bit                offer_live = 1'b0;
    bit                tx_idle_on = 1'b0;
    bit                rx_idle_on = 1'b0;
    logic              rx_block = 1'b0;
    logic              rx_ready_next;
    int                tx_gap = 0;
    int                rx_gap = 0;
    bsab_pkg::pixel_t  want;

    int queued_total = 0;
    int texel_cnt = 0;
    int pixel_cnt = 0;
    int result_cnt = 0;
    int settings_cnt = 0;
    int fault_cnt = 0;

    bilinear_sample_alpha_blend_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic bsab_pkg::chan_t lerp16(input bsab_pkg::chan_t a,
                                               input bsab_pkg::chan_t b,
                                               input bsab_pkg::chan_t f);
        logic [47:0] acc;
        acc = 48'(a) * 48'(bsab_pkg::CHAN_MAX - f) + 48'(b) * 48'(f)
            + 48'(bsab_pkg::CHAN_MAX);
        return acc[31:16];
    endfunction

    function automatic logic [ADDR_W-1:0] tap_addr(input logic [31:0] u,
                                                   input logic [31:0] v,
                                                   input logic [6:0] pitch,
                                                   input bit dx, input bit dy);
        longint base;
        base = longint'($signed(v[31:16])) * longint'(pitch) + longint'($signed(u[31:16]));
        if (dx)
            base = base + 64'sd1;
        if (dy)
            base = base + longint'(pitch);
        return base[ADDR_W-1:0];
    endfunction

    function automatic void advance_pos(inout logic [31:0] u, inout logic [31:0] v,
                                        input logic row_end);
        if (row_end) begin
            u = {10'd0, start_u_r};
            v = v + {{8{step_v_r[23]}}, step_v_r};
        end else begin
            u = u + {{8{step_u_r[23]}}, step_u_r};
        end
    endfunction

    function automatic bsab_pkg::pixel_t rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic bsab_pkg::chan_t rand_mask();
        int r;
        r = $urandom_range(0, 19);
        if (r < 3)
            return '0;
        if (r == 3)
            return bsab_pkg::CHAN_MAX;
        if (r == 4)
            return 16'd1;
        return 16'($urandom());
    endfunction

    function automatic logic [21:0] rand_start();
        if ($urandom_range(0, 4) == 0)
            return 22'h3FFFFF;
        if ($urandom_range(0, 1) == 0)
            return 22'($urandom_range(0, 8 * 65536));
        return 22'($urandom_range(0, 4194303));
    endfunction

    function automatic logic [23:0] rand_step();
        int r;
        int s;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 24'h800000;
        if (r == 1)
            return 24'h7FFFFF;
        if (r < 4)
            return 24'h010000;
        s = $urandom_range(0, 262144);
        s = s - 131072;
        return s[23:0];
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // update the scoreboard with one accepted request
    task automatic predict_blend(input blend_req_t req);
        bsab_pkg::pixel_t t00, t10, t01, t11, res;
        bsab_pkg::chan_t  top, bot, smp;
        if (req.cmd == bsab_pkg::CMD_TEXEL) begin
            blur_img[req.tex_idx] = req.tex_val;
            texel_cnt++;
        end else begin
            if (req.region_first) begin
                pos_u = {10'd0, start_u_r};
                pos_v = {10'd0, start_v_r};
            end
            res = req.dest;
            if (req.mask != '0) begin
                t00 = blur_img[tap_addr(pos_u, pos_v, pitch_r, 1'b0, 1'b0)];
                t10 = blur_img[tap_addr(pos_u, pos_v, pitch_r, 1'b1, 1'b0)];
                t01 = blur_img[tap_addr(pos_u, pos_v, pitch_r, 1'b0, 1'b1)];
                t11 = blur_img[tap_addr(pos_u, pos_v, pitch_r, 1'b1, 1'b1)];
                for (int c = 0; c < CHANNELS; c++) begin
                    top = lerp16(t00[CHAN_W*c +: CHAN_W], t10[CHAN_W*c +: CHAN_W],
                                 pos_u[FRAC_W-1:0]);
                    bot = lerp16(t01[CHAN_W*c +: CHAN_W], t11[CHAN_W*c +: CHAN_W],
                                 pos_u[FRAC_W-1:0]);
                    smp = lerp16(top, bot, pos_v[FRAC_W-1:0]);
                    res[CHAN_W*c +: CHAN_W] = lerp16(req.dest[CHAN_W*c +: CHAN_W], smp,
                                                     req.mask);
                end
            end
            blend_due.push_back(res);
            advance_pos(pos_u, pos_v, req.row_last);
            pixel_cnt++;
        end
    endtask

    task automatic queue_texel(input logic [ADDR_W-1:0] idx, input bsab_pkg::pixel_t val);
        blend_req_t req;
        req.cmd          = bsab_pkg::CMD_TEXEL;
        req.tex_idx      = idx;
        req.tex_val      = val;
        req.mask         = 16'($urandom());
        req.dest         = rand64();
        req.row_last     = 1'($urandom_range(0, 1));
        req.region_first = 1'($urandom_range(0, 1));
        pending_requests.push_back(req);
        filled[idx] = 1'b1;
        queued_total++;
    endtask

    // queue a write for any tap the pixel will read that has never been written, then the pixel
    task automatic queue_pixel(input bsab_pkg::chan_t mask, input bsab_pkg::pixel_t dest,
                               input logic row_end, input logic restart);
        blend_req_t        req;
        logic [ADDR_W-1:0] a;
        if (restart) begin
            plan_u = {10'd0, start_u_r};
            plan_v = {10'd0, start_v_r};
        end
        if (mask != '0) begin
            for (int dy = 0; dy < 2; dy++) begin
                for (int dx = 0; dx < 2; dx++) begin
                    a = tap_addr(plan_u, plan_v, pitch_r, dx != 0, dy != 0);
                    if (!filled[a])
                        queue_texel(a, rand64());
                end
            end
        end
        req.cmd          = bsab_pkg::CMD_PIXEL;
        req.tex_idx      = ADDR_W'($urandom());
        req.tex_val      = rand64();
        req.mask         = mask;
        req.dest         = dest;
        req.row_last     = row_end;
        req.region_first = restart;
        pending_requests.push_back(req);
        queued_total++;
        advance_pos(plan_u, plan_v, row_end);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            bsab_pkg::REG_PITCH:   pitch_r   = val[6:0];
            bsab_pkg::REG_START_U: start_u_r = val[21:0];
            bsab_pkg::REG_START_V: start_v_r = val[21:0];
            bsab_pkg::REG_STEP_U:  step_u_r  = val;
            bsab_pkg::REG_STEP_V:  step_v_r  = val;
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [6:0] pitch, input logic [21:0] su,
                                input logic [21:0] sv, input logic [23:0] stu,
                                input logic [23:0] stv);
        write_reg(bsab_pkg::REG_PITCH, {17'd0, pitch});
        write_reg(bsab_pkg::REG_START_U, {2'd0, su});
        write_reg(bsab_pkg::REG_START_V, {2'd0, sv});
        write_reg(bsab_pkg::REG_STEP_U, stu);
        write_reg(bsab_pkg::REG_STEP_V, stv);
        settings_cnt++;
    endtask

    // hold until every request is taken and every result is back, then let
    // trailing texel writes settle
    task automatic drain_all();
        while (pending_requests.size() != 0 || offer_live || blend_due.size() != 0)
            @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_blend(offer);
                offer_live = 1'b0;
            end
            if (!offer_live) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (pending_requests.size() != 0) begin
                    offer = pending_requests.pop_front();
                    offer_live = 1'b1;
                    tx_gap = tx_idle_on ? gap_len() : 0;
                end
            end
            s_tvalid <= offer_live;
            s_tdata  <= {4'd0, offer.dest, offer.mask, offer.tex_val, offer.tex_idx};
            s_tuser  <= {offer.region_first, offer.cmd};
            s_tlast  <= offer.row_last;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                result_cnt++;
                if (blend_due.size() == 0) begin
                    fault_cnt++;
                    if (fault_cnt <= 10)
                        $display("unrequested blended_pixel %016h", m_tdata);
                end else begin
                    want = blend_due.pop_front();
                    if (m_tdata !== want) begin
                        fault_cnt++;
                        if (fault_cnt <= 10)
                            $display({"blended_pixel mismatch on result %0d: ",
                                      "expected %016h, got %016h"},
                                     result_cnt, want, m_tdata);
                    end
                end
            end
            if (rx_block) begin
                rx_ready_next = 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                rx_ready_next = 1'b0;
            end else begin
                rx_ready_next = 1'b1;
                rx_gap = rx_idle_on ? gap_len() : 0;
            end
            m_tready <= rx_ready_next;
        end
    end

    initial begin
        #20_000_000;
        $display("timeout with %0d results outstanding", blend_due.size());
        $display("bilinear_sample_alpha_blend_unit verification failed");
        $finish;
    end

    initial begin
        int         ph;
        int         first;
        int         rows;
        int         len;
        int         r;
        logic [6:0] pitch_pick;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: origin taps, zero mask, extreme masks and pixels
        queue_texel(12'd0, '1);
        queue_texel(12'd4095, '0);
        queue_texel(12'd1, 64'h0000_FFFF_8000_0001);
        queue_texel(12'd64, 64'hFFFF_0000_7FFF_FFFE);
        queue_texel(12'd65, rand64());
        queue_pixel(bsab_pkg::CHAN_MAX, '0, 1'b0, 1'b1);
        queue_pixel('0, '1, 1'b0, 1'b0);
        queue_pixel(16'd1, rand64(), 1'b1, 1'b0);
        queue_pixel(16'h8000, '1, 1'b0, 1'b0);
        queue_pixel(bsab_pkg::CHAN_MAX, '1, 1'b1, 1'b0);
        drain_all();

        // zero pitch, largest start, extreme steps: coordinates wrap
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        program_regs(7'd0, 22'h3FFFFF, 22'h3FFFFF, 24'h800000, 24'h7FFFFF);
        queue_pixel(bsab_pkg::CHAN_MAX, rand64(), 1'b0, 1'b1);
        queue_pixel(rand_mask(), rand64(), 1'b0, 1'b0);
        queue_pixel(rand_mask(), rand64(), 1'b1, 1'b0);
        queue_pixel(16'h7FFF, rand64(), 1'b0, 1'b0);
        queue_pixel('0, rand64(), 1'b1, 1'b0);
        drain_all();

        // pitch above the image width, negative fractional steps: negative taps
        program_regs(7'd127, '0, '0, 24'hFF8000, 24'hFF4000);
        for (int i = 0; i < 6; i++)
            queue_pixel(rand_mask(), rand64(), i % 3 == 2, i == 0);
        drain_all();

        ph = 0;
        while (queued_total < 820) begin
            r = $urandom_range(0, 9);
            case (r)
                0: pitch_pick = 7'd1;
                1: pitch_pick = 7'd64;
                2: pitch_pick = 7'd127;
                3: pitch_pick = 7'd0;
                default: pitch_pick = 7'($urandom_range(1, 64));
            endcase
            program_regs(pitch_pick, rand_start(), rand_start(), rand_step(), rand_step());
            tx_idle_on = (ph != 0) && ($urandom_range(0, 3) != 0);
            rx_idle_on = $urandom_range(0, 3) != 0;

            first = queued_total;
            while (queued_total - first < 100) begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    queue_texel(ADDR_W'($urandom_range(0, BLUR_TEXELS - 1)), rand64());
                end else if (r < 16) begin
                    queue_pixel(rand_mask(), rand64(), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)));
                end else begin
                    rows = $urandom_range(1, 4);
                    for (int y = 0; y < rows; y++) begin
                        len = $urandom_range(1, 6);
                        for (int x = 0; x < len; x++)
                            queue_pixel(rand_mask(), rand64(), x == len - 1, y == 0 && x == 0);
                    end
                end
            end

            if (ph == 0) begin
                @(posedge aclk);
                rx_block <= 1'b1;
                repeat (400) @(posedge aclk);
                rx_block <= 1'b0;
            end
            drain_all();
            ph++;
        end

        $display("covered %0d texel writes and %0d pixel requests over %0d register settings",
                 texel_cnt, pixel_cnt, settings_cnt + 1);
        $display("checked %0d blended pixels, %0d faults", result_cnt, fault_cnt);
        if (fault_cnt == 0) begin
            $display("bilinear_sample_alpha_blend_unit verification clean");
        end else begin
            $display("bilinear_sample_alpha_blend_unit verification failed");
        end
        $finish;
    end

endmodule
